FILE: hw/rtl/bump_allocator_with_address_translation_unit_defines.svh
// Assertion helpers shared by the allocator RTL.
`ifndef BUMP_ALLOCATOR_WITH_ADDRESS_TRANSLATION_UNIT_DEFINES_SVH
`define BUMP_ALLOCATOR_WITH_ADDRESS_TRANSLATION_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked check, disabled while reset is high
`define BAT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
// clocked check that also holds through reset
`define BAT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");
`else
`define BAT_ASSERT(lbl, clk, rst, prop)
`define BAT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: hw/rtl/bat_pkg.sv
package bat_pkg;

   // operation codes on the request channel
   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_V2P   = 2'd1,
      OP_P2V   = 2'd2,
      OP_FREE  = 2'd3
   } op_type;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      CSR_PRESENT   = 2'd0,
      CSR_VIRT_BASE = 2'd1,
      CSR_PHYS_BASE = 2'd2,
      CSR_BYTES     = 2'd3
   } csr_index_type;

   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned SIZE_W  = 25;
   localparam int unsigned ALIGN_W = 16;

   typedef struct packed {
      logic              present;
      logic [ADDR_W-1:0] virt_base;
      logic [ADDR_W-1:0] phys_base;
      logic [SIZE_W-1:0] bytes;
   } region_cfg_type;

   typedef struct packed {
      op_type             op;
      logic [ADDR_W-1:0]  address;
      logic [ALIGN_W-1:0] align_req;
      logic [SIZE_W-1:0]  request_bytes;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] result_address;
      logic              ok;
   } rsp_type;

endpackage

FILE: hw/rtl/bat_if.sv
// Request channel: one operation per transfer.
interface bat_req_if import bat_pkg::*; ();
   logic               valid;
   logic               ready;
   op_type             op;
   logic [ADDR_W-1:0]  address;
   logic [ALIGN_W-1:0] align_req;
   logic [SIZE_W-1:0]  request_bytes;

   modport source (output valid, op, address, align_req, request_bytes, input ready);
   modport sink   (input valid, op, address, align_req, request_bytes, output ready);
endinterface

// Response channel: one result per transfer.
interface bat_rsp_if import bat_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] result_address;
   logic              ok;

   modport source (output valid, result_address, ok, input ready);
   modport sink   (input valid, result_address, ok, output ready);
endinterface

FILE: hw/rtl/bat_csr.sv
module bat_csr import bat_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  csr_index_type       csr_index,
   input  logic [ADDR_W-1:0]   csr_wdata,
   output region_cfg_type      cfg
);

   region_cfg_type cfg_ff;
   region_cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PRESENT:   cfg_in.present   = csr_wdata[0];
            CSR_VIRT_BASE: cfg_in.virt_base = csr_wdata;
            CSR_PHYS_BASE: cfg_in.phys_base = csr_wdata;
            CSR_BYTES:     cfg_in.bytes     = csr_wdata[SIZE_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/bat_alloc.sv
`include "bump_allocator_with_address_translation_unit_defines.svh"

module bat_alloc import bat_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  req_type        req,
   input  region_cfg_type cfg,
   output rsp_type        rsp
);

   localparam logic [ADDR_W-1:0] BANK_START_MASK = 32'hFFC0_0000;
   localparam int unsigned       MASK_W          = 10;

   logic [ADDR_W-1:0] used_offset_ff;
   logic [ADDR_W-1:0] used_offset_in;

   logic [MASK_W-1:0] smear;
   logic [MASK_W-1:0] align_mask;
   logic [ADDR_W-1:0] mask32;
   logic [ADDR_W-1:0] used_round;
   logic [ADDR_W-1:0] bytes32;
   logic [ADDR_W-1:0] size32;
   logic              fits;
   logic [ADDR_W-1:0] lo_used;
   logic [ADDR_W-1:0] lo_end;
   logic              crosses;
   logic [ADDR_W-1:0] va_start;
   logic [ADDR_W-1:0] va_end;
   logic [ADDR_W-1:0] bank_start;

   // alignment clamp: largest power of two not above the request, 1..1024
   always_comb begin
      smear = req.align_req[MASK_W-1:0];
      smear = smear | (smear >> 1);
      smear = smear | (smear >> 2);
      smear = smear | (smear >> 4);
      smear = smear | (smear >> 8);
      if (|req.align_req[ALIGN_W-1:MASK_W]) begin
         align_mask = '1;
      end else begin
         align_mask = smear >> 1;
      end
   end

   // round offset up, fit test against the region size
   assign mask32     = {{(ADDR_W-MASK_W){1'b0}}, align_mask};
   assign used_round = (used_offset_ff + mask32) & ~mask32;
   assign bytes32    = {{(ADDR_W-SIZE_W){1'b0}}, cfg.bytes};
   assign size32     = {{(ADDR_W-SIZE_W){1'b0}}, req.request_bytes};
   assign fits       = (used_round <= bytes32) && ((bytes32 - used_round) >= size32);

   // 4 MB bank crossing on the low 24 bits of the virtual address
   assign lo_used    = {8'h00, cfg.virt_base[23:0]} + used_round;
   assign lo_end     = lo_used + size32;
   assign crosses    = lo_used[24:22] != lo_end[24:22];
   assign va_start   = cfg.virt_base + used_round;
   assign va_end     = va_start + size32;
   assign bank_start = va_end & BANK_START_MASK;

   // response and next offset
   always_comb begin
      used_offset_in     = used_offset_ff;
      rsp.result_address = '0;
      rsp.ok             = 1'b0;
      if (req.op == OP_FREE) begin
         used_offset_in = '0;
         rsp.ok         = 1'b1;
      end else if (cfg.present) begin
         used_offset_in = used_round;
         if (fits) begin
            rsp.ok = 1'b1;
            if (crosses) begin
               rsp.result_address = bank_start;
               used_offset_in     = size32 + (bank_start - cfg.virt_base);
            end else begin
               rsp.result_address = va_start;
               used_offset_in     = used_round + size32;
            end
         end
      end
   end

   // bump pointer, updated only for alloc and free
   always_ff @(posedge clock) begin
      if (reset) begin
         used_offset_ff <= '0;
      end else if (fire && (req.op == OP_ALLOC || req.op == OP_FREE)) begin
         used_offset_ff <= used_offset_in;
      end
   end

   `BAT_ASSERT(a_free_clears, clock, reset, fire && req.op == OP_FREE |=> used_offset_ff == '0)
   `BAT_ASSERT(a_absent_holds, clock, reset, fire && req.op == OP_ALLOC && !cfg.present |=> $stable(used_offset_ff))
   `BAT_ASSERT(a_idle_holds, clock, reset, !fire |=> $stable(used_offset_ff))

endmodule

FILE: hw/rtl/bat_xlate.sv
module bat_xlate import bat_pkg::*; (
   input  req_type        req,
   input  region_cfg_type cfg,
   output rsp_type        rsp
);

   localparam logic [ADDR_W-1:0] SEG_ADDR_MASK   = 32'h1FFF_FFFF;
   localparam logic [3:0]        SEG_MAPPED_BITS = 4'hB;

   logic [ADDR_W-1:0] bytes32;
   logic [ADDR_W-1:0] virt_end;
   logic [ADDR_W-1:0] phys_end;
   logic              in_virt;
   logic              in_phys;
   logic              seg_mapped;

   // region windows; an end that wraps past 2^32 matches nothing
   assign bytes32    = {{(ADDR_W-SIZE_W){1'b0}}, cfg.bytes};
   assign virt_end   = cfg.virt_base + bytes32;
   assign phys_end   = cfg.phys_base + bytes32;
   assign in_virt    = cfg.present && (req.address >= cfg.virt_base) && (req.address < virt_end);
   assign in_phys    = cfg.present && (req.address >= cfg.phys_base) && (req.address < phys_end);
   assign seg_mapped = |(req.address[31:28] & SEG_MAPPED_BITS);

   always_comb begin
      rsp.result_address = '0;
      rsp.ok             = 1'b0;
      if (req.op == OP_V2P) begin
         if (in_virt) begin
            rsp.result_address = cfg.phys_base + (req.address - cfg.virt_base);
            rsp.ok             = 1'b1;
         end else if (seg_mapped) begin
            // unmapped kernel segment fallback
            rsp.result_address = req.address & SEG_ADDR_MASK;
            rsp.ok             = 1'b1;
         end else begin
            rsp.result_address = '1;
         end
      end else if (in_phys) begin
         rsp.result_address = cfg.virt_base + (req.address - cfg.phys_base);
         rsp.ok             = 1'b1;
      end
   end

endmodule

FILE: hw/rtl/bump_allocator_with_address_translation_unit.sv
// Bump-pointer allocator over one reserved region with virtual/physical
// address translation. Each request (allocate, virt->phys, phys->virt, free
// all) yields exactly one response. A request is registered on transfer and
// its response is registered in the output stage once that stage is empty or
// draining; one request is taken every cycle while the response side does not
// stall, since the allocate path reads and updates the offset register in the
// same cycle. The user must write region registers through the csr port only
// while no request is in flight; the block itself does not enforce this.
`include "bump_allocator_with_address_translation_unit_defines.svh"

module bump_allocator_with_address_translation_unit import bat_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   bat_req_if.sink              req_if,
   bat_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  csr_index_type        csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata
);

   region_cfg_type cfg;

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   rsp_type alloc_rsp;
   rsp_type xlate_rsp;
   logic    advance;
   logic    req_take;

   bat_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bat_alloc u_alloc (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (in_data_ff),
      .cfg   (cfg),
      .rsp   (alloc_rsp)
   );

   bat_xlate u_xlate (
      .req (in_data_ff),
      .cfg (cfg),
      .rsp (xlate_rsp)
   );

   // stage handshake: input stage drains into the response register
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   // response select
   always_comb begin
      case (in_data_ff.op) inside
         OP_ALLOC, OP_FREE: out_data_in = alloc_rsp;
         default:           out_data_in = xlate_rsp;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= '{op:            req_if.op,
                         address:       req_if.address,
                         align_req:     req_if.align_req,
                         request_bytes: req_if.request_bytes};
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.result_address = out_data_ff.result_address;
   assign rsp_if.ok             = out_data_ff.ok;

   `BAT_ASSERT(a_take_fills, clock, reset, req_take |=> in_valid_ff)
   `BAT_ASSERT(a_fail_value, clock, reset, out_valid_ff && !out_data_ff.ok |-> out_data_ff.result_address == '0 || out_data_ff.result_address == '1)
   `BAT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !in_valid_ff && !out_valid_ff)

endmodule

FILE: verif/bump_allocator_with_address_translation_unit_tb.sv
`timescale 1ns / 1ps

module bump_allocator_with_address_translation_unit_tb;
   import bat_pkg::*;

   localparam bit [31:0]   BANK_FIELD_MASK = 32'h01C0_0000;
   localparam bit [31:0]   BANK_START_MASK = 32'hFFC0_0000;
   localparam bit [31:0]   LOW24_MASK      = 32'h00FF_FFFF;
   localparam bit [31:0]   SEG_ADDR_MASK   = 32'h1FFF_FFFF;
   localparam bit [3:0]    SEG_MAPPED_BITS = 4'hB;
   localparam bit [31:0]   MAX_ALIGN       = 32'd1024;
   localparam bit [24:0]   MAX_SIZE        = 25'h100_0000;
   localparam int unsigned HOLD_CYCLES     = 60;
   localparam int unsigned DRAIN_LIMIT     = 2000;
   localparam int unsigned MAX_REPORTS     = 100;
   localparam int unsigned NUM_PHASES      = 7;

   // tracks the region registers and bump offset, queues expected responses
   class bump_alloc_scoreboard;
      bit          present;
      bit [31:0]   virt_base;
      bit [31:0]   phys_base;
      bit [31:0]   region_bytes;
      bit [31:0]   used_offset;
      rsp_type     expected_rsps[$];
      int unsigned mismatch_count;

      function void write_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_PRESENT:   present      = value[0];
            CSR_VIRT_BASE: virt_base    = value;
            CSR_PHYS_BASE: phys_base    = value;
            CSR_BYTES:     region_bytes = {7'd0, value[SIZE_W-1:0]};
         endcase
      endfunction

      // largest power of two from 1 to 1024 not above the request
      function bit [31:0] clamp_align(bit [15:0] req);
         bit [31:0] align;
         align = MAX_ALIGN;
         while (align > 1 && req < align) align = align >> 1;
         return align;
      endfunction

      // window end wraps at 32 bits, so a wrapped window matches nothing
      function bit in_window(bit [31:0] addr, bit [31:0] base);
         bit [31:0] top;
         top = base + region_bytes;
         return present && addr >= base && addr < top;
      endfunction

      function void note_request(req_type item);
         rsp_type   exp_rsp;
         bit [31:0] align;
         bit [31:0] rounded;
         bit [31:0] low24;
         bit [31:0] size;
         bit [31:0] addr;
         exp_rsp = '0;
         size    = {7'd0, item.request_bytes};
         addr    = item.address;
         case (item.op)
            OP_ALLOC: begin
               if (present) begin
                  align       = clamp_align(item.align_req);
                  rounded     = (used_offset + align - 1) & ~(align - 1);
                  // rounded offset sticks even when the request does not fit
                  used_offset = rounded;
                  if (rounded <= region_bytes && region_bytes - rounded >= size) begin
                     low24 = virt_base & LOW24_MASK;
                     if (((low24 + rounded) & BANK_FIELD_MASK) !=
                         ((low24 + rounded + size) & BANK_FIELD_MASK)) begin
                        // crosses a 4 MB bank: move to start of the bank holding the end
                        exp_rsp.result_address =
                           (virt_base + rounded + size) & BANK_START_MASK;
                        used_offset = size + (exp_rsp.result_address - virt_base);
                     end else begin
                        exp_rsp.result_address = virt_base + rounded;
                        used_offset = rounded + size;
                     end
                     exp_rsp.ok = 1'b1;
                  end
               end
            end
            OP_V2P: begin
               if (in_window(addr, virt_base)) begin
                  exp_rsp.result_address = phys_base + (addr - virt_base);
                  exp_rsp.ok = 1'b1;
               end else if ((addr[31:28] & SEG_MAPPED_BITS) != 4'h0) begin
                  exp_rsp.result_address = addr & SEG_ADDR_MASK;
                  exp_rsp.ok = 1'b1;
               end else begin
                  exp_rsp.result_address = 32'hFFFF_FFFF;
               end
            end
            OP_P2V: begin
               if (in_window(addr, phys_base)) begin
                  exp_rsp.result_address = virt_base + (addr - phys_base);
                  exp_rsp.ok = 1'b1;
               end
            end
            OP_FREE: begin
               used_offset = 32'd0;
               exp_rsp.ok  = 1'b1;
            end
         endcase
         expected_rsps.push_back(exp_rsp);
      endfunction

      task report_mismatch(string what);
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, what);
      endtask

      task check_rsp(logic [31:0] addr, logic ok);
         rsp_type exp_rsp;
         if (expected_rsps.size() == 0) begin
            report_mismatch("response transfer with no request outstanding");
            return;
         end
         exp_rsp = expected_rsps.pop_front();
         if (addr !== exp_rsp.result_address)
            report_mismatch($sformatf("result_address %h, expected %h",
                                      addr, exp_rsp.result_address));
         if (ok !== exp_rsp.ok)
            report_mismatch($sformatf("ok %b, expected %b", ok, exp_rsp.ok));
      endtask

      function int unsigned pending();
         return expected_rsps.size();
      endfunction
   endclass

   typedef struct {
      bit          present;
      bit [31:0]   virt_base;
      bit [31:0]   phys_base;
      bit [24:0]   bytes;
      int unsigned items;
      bit          quiet;
   } region_setting_type;

   logic clock;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [ADDR_W-1:0] csr_wdata;

   bat_req_if req_ch ();
   bat_rsp_if rsp_ch ();

   bump_alloc_scoreboard sb;
   region_setting_type   settings [NUM_PHASES];
   bit                   quiet;
   int unsigned          rsp_transfers;

   bump_allocator_with_address_translation_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic req_type make_req(op_type op, logic [31:0] address,
                                        logic [15:0] align_req, logic [24:0] request_bytes);
      req_type item;
      item.op            = op;
      item.address       = address;
      item.align_req     = align_req;
      item.request_bytes = request_bytes;
      return item;
   endfunction

   function automatic op_type pick_op();
      case ($urandom_range(0, 3))
         0:       return OP_ALLOC;
         1:       return OP_V2P;
         2:       return OP_P2V;
         default: return OP_FREE;
      endcase
   endfunction

   // mostly well-formed ops aimed at the region, some pure noise
   function automatic req_type random_req(region_setting_type s);
      req_type     item;
      int unsigned pick;
      int unsigned size_pick;
      item.op            = pick_op();
      item.address       = $urandom;
      item.align_req     = 16'($urandom);
      item.request_bytes = 25'($urandom_range(0, MAX_SIZE));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         item.op = OP_ALLOC;
         if ($urandom_range(0, 3) != 0) item.align_req = 16'($urandom_range(0, 1100));
         size_pick = $urandom_range(0, 9);
         if (size_pick < 6)      item.request_bytes = 25'($urandom_range(0, 512));
         else if (size_pick < 9) item.request_bytes = 25'($urandom_range(0, 1 << 18));
      end else if (pick < 65) begin
         item.op = OP_V2P;
         if ($urandom_range(0, 1) != 0) item.address = s.virt_base + $urandom_range(0, s.bytes);
      end else if (pick < 85) begin
         item.op = OP_P2V;
         if ($urandom_range(0, 1) != 0) item.address = s.phys_base + $urandom_range(0, s.bytes);
      end else if (pick < 90) begin
         item.op = OP_FREE;
      end
      return item;
   endfunction

   // one request transfer, with a random gap before it unless the phase is quiet
   task automatic send(input req_type item);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.op            <= item.op;
      req_ch.address       <= item.address;
      req_ch.align_req     <= item.align_req;
      req_ch.request_bytes <= item.request_bytes;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(item);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   // wait for every outstanding response, then let the pipeline settle
   task automatic drain();
      int unsigned waited;
      waited = 0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (sb.pending() != 0) begin
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending()));
         sb.expected_rsps.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   // response side: random stalls plus two long hold-offs to back up the block
   initial begin
      int unsigned stall;
      rsp_transfers = 0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 4);
         if (rsp_transfers == 150 || rsp_transfers == 420) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         sb.check_rsp(rsp_ch.result_address, rsp_ch.ok);
         rsp_transfers++;
      end
   end

   // main sequence: per phase program the region, run any directed ops then random ops
   initial begin
      sb            = new();
      quiet         = 1'b0;
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= CSR_PRESENT;
      csr_wdata            <= '0;
      req_ch.valid         <= 1'b0;
      req_ch.op            <= OP_ALLOC;
      req_ch.address       <= '0;
      req_ch.align_req     <= '0;
      req_ch.request_bytes <= '0;

      // absent region; full-size region; bank edge with wrapped phys window;
      // wrapped virt window; empty region; mid-size region; absent at extremes
      settings[0] = '{1'b0, 32'h8000_0000, 32'h0000_0000, 25'h010_0000,  40, 1'b0};
      settings[1] = '{1'b1, 32'h8000_0000, 32'h0200_0000, MAX_SIZE,     100, 1'b0};
      settings[2] = '{1'b1, 32'h123F_F000, 32'hFFFF_0000, 25'h002_0000, 110, 1'b0};
      settings[3] = '{1'b1, 32'hFFFF_F000, 32'h0000_0000, 25'h000_2000,  70, 1'b1};
      settings[4] = '{1'b1, 32'h0000_0000, 32'h3000_0000, 25'h000_0000,  40, 1'b0};
      settings[5] = '{1'b1, 32'hA07F_0000, 32'h1000_0000, 25'h080_0000, 170, 1'b0};
      settings[6] = '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, MAX_SIZE,      45, 1'b0};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_csr(CSR_PRESENT,   {31'd0, settings[p].present});
         write_csr(CSR_VIRT_BASE, settings[p].virt_base);
         write_csr(CSR_PHYS_BASE, settings[p].phys_base);
         write_csr(CSR_BYTES,     {7'd0, settings[p].bytes});
         csr_we <= 1'b0;
         quiet = settings[p].quiet;

         if (p == 0) begin
            // region absent: alloc fails, kernel segment fallback, lookup misses
            send(make_req(OP_ALLOC, 32'h0,         16'd8, 25'd64));
            send(make_req(OP_V2P,   32'h9000_0010, 16'd0, 25'd0));
            send(make_req(OP_V2P,   32'h4123_4567, 16'd0, 25'd0));
            send(make_req(OP_P2V,   32'h0000_1000, 16'd0, 25'd0));
            send(make_req(OP_FREE,  32'h0,         16'd0, 25'd0));
         end
         if (p == 1) begin
            // whole region in one shot, then overflow
            send(make_req(OP_ALLOC, 32'h0, 16'd0,      MAX_SIZE));
            send(make_req(OP_ALLOC, 32'h0, 16'd1,      25'd1));
            send(make_req(OP_FREE,  32'h0, 16'd0,      25'd0));
            // zero, odd and oversized alignments
            send(make_req(OP_ALLOC, 32'h0, 16'd0,      25'd100));
            send(make_req(OP_ALLOC, 32'h0, 16'd3,      25'd10));
            send(make_req(OP_ALLOC, 32'h0, 16'hFFFF,   25'd5));
            // bank crossing, then a failed fit and a zero-byte alloc with 1024 alignment
            send(make_req(OP_ALLOC, 32'h0, 16'd1,      25'h050_0000));
            send(make_req(OP_ALLOC, 32'h0, 16'd1,      25'h0FF_FFFF));
            send(make_req(OP_ALLOC, 32'h0, 16'd1024,   25'd0));
            // window edges and segment fallback
            send(make_req(OP_V2P, 32'h8000_0000, 16'd0, 25'd0));
            send(make_req(OP_V2P, 32'h80FF_FFFF, 16'd0, 25'd0));
            send(make_req(OP_V2P, 32'h8100_0000, 16'd0, 25'd0));
            send(make_req(OP_V2P, 32'h4000_0000, 16'd0, 25'd0));
            send(make_req(OP_V2P, 32'hFFFF_FFFF, 16'd0, 25'd0));
            send(make_req(OP_V2P, 32'h0000_1234, 16'd0, 25'd0));
            send(make_req(OP_P2V, 32'h0200_0000, 16'd0, 25'd0));
            send(make_req(OP_P2V, 32'h02FF_FFFF, 16'd0, 25'd0));
            send(make_req(OP_P2V, 32'h0300_0000, 16'd0, 25'd0));
            send(make_req(OP_P2V, 32'h0000_0000, 16'd0, 25'd0));
            send(make_req(OP_FREE, 32'hFFFF_FFFF, 16'hFFFF, MAX_SIZE));
         end

         repeat (settings[p].items) send(random_req(settings[p]));
         req_ch.valid <= 1'b0;
         drain();
      end

      if (sb.mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/bat_pkg.sv
hw/rtl/bat_if.sv
hw/rtl/bat_csr.sv
hw/rtl/bat_alloc.sv
hw/rtl/bat_xlate.sv
hw/rtl/bump_allocator_with_address_translation_unit.sv
verif/bump_allocator_with_address_translation_unit_tb.sv
